FILE: src/tcw_pkg.sv
package tcw_pkg;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic [7:0] ATTR_RESET = 8'h0F;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  char_code;
      logic [10:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_location;
      logic [15:0] read_cell;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic sweep_start;
      logic fill;
      logic fill_reset;
      logic move;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       scroll;
      logic       move_last;
      logic       fill_last;
   } status_type;

endpackage

FILE: src/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells
// (character low byte, attribute high byte) plus a cursor.
// Request channel: start with req_data (opcode, char_code, cell_address);
// a transaction is taken on a clock edge with start high and busy low.
// Result channel: rsp_valid pulses for one cycle with rsp_data (cursor
// location after the step, and the cell for an in-range read, zero otherwise).
// The receiver cannot stall; each result is shown for exactly one cycle.
// Attribute register: csr_valid/csr_wdata, csr_ready is always high.
// Put, read and no-op pass through the DECODE and FINISH states before
// rsp_valid is registered; busy stays high until the block is back in IDLE.
// Clear sweeps the screen memory, one cell a cycle. A put that scrolls
// moves the screen up one line, then blanks the bottom line.
// Reset: cursor to the top left, attribute to 0x0F, and a clearing pass
// writes blank cells with busy held high; attribute writes are taken
// during that pass.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/tcw_ctrl.sv
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            // blank the screen with the reset attribute
            cmd.fill       = 1'b1;
            cmd.fill_reset = 1'b1;
            if (status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.opcode)
               OP_PUT: begin
                  cmd.step = 1'b1;
                  if (status.scroll) begin
                     cmd.sweep_start = 1'b1;
                     state_in        = S_MOVE;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               OP_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  state_in        = S_FILL;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            if (status.move_last) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (status.fill_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: src/tcw_datapath.sv
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_valid,
   input  logic [7:0] csr_wdata,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   logic [15:0]   mem [CELLS];
   logic [15:0]   rd_data_ff;

   req_type       req_ff;
   logic [7:0]    attr_ff;
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [AW-1:0] cnt_ff;
   logic [AW-1:0] cnt_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [CW+3:0] col_ext;
   logic [CW+3:0] tab_ext;
   logic [RW:0]   row_ext;
   logic          printable;
   logic          scroll;
   logic [31:0]   loc_wide;
   logic [31:0]   src_wide;
   logic [31:0]   req_addr_wide;
   logic          req_in_range;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;
   logic [AW-1:0] mem_ra;

   assign printable     = !req_ff.char_code[7] && (req_ff.char_code[6:5] != 2'b00);
   assign loc_wide      = 32'(row_ff) * 32'(COLUMNS) + 32'(col_ff);
   assign src_wide      = 32'(cnt_ff) + 32'(COLUMNS);
   assign req_addr_wide = 32'(req_ff.cell_address);
   assign req_in_range  = (req_addr_wide < 32'(CELLS));

   // cursor step for one put byte, scroll clamp included
   always_comb begin
      col_ext = (CW+4)'(col_ff);
      row_ext = (RW+1)'(row_ff);
      tab_ext = col_ext + (CW+4)'(8);
      tab_ext[2:0] = 3'b000;
      case (req_ff.char_code)
         CHAR_BACKSPACE: begin
            if (col_ff != '0) begin
               col_ext = col_ext - (CW+4)'(1);
            end
         end
         CHAR_TAB: begin
            col_ext = tab_ext;
         end
         CHAR_NEWLINE: begin
            col_ext = '0;
            row_ext = row_ext + (RW+1)'(1);
         end
         default: begin
            if (printable) begin
               col_ext = col_ext + (CW+4)'(1);
            end
         end
      endcase
      if (col_ext >= (CW+4)'(COLUMNS)) begin
         col_ext = '0;
         row_ext = row_ext + (RW+1)'(1);
      end
      scroll = (row_ext >= (RW+1)'(ROWS));
      if (scroll) begin
         row_ext = (RW+1)'(ROWS - 1);
      end
      col_in = col_ext[CW-1:0];
      row_in = row_ext[RW-1:0];
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = cnt_ff;
      mem_wd = {attr_ff, CHAR_SPACE};
      mem_ra = req_addr_wide[AW-1:0];
      if (cmd.step && printable) begin
         mem_we = 1'b1;
         mem_wa = loc_wide[AW-1:0];
         mem_wd = {attr_ff, req_ff.char_code};
      end else if (cmd.fill) begin
         mem_we = 1'b1;
         if (cmd.fill_reset) begin
            mem_wd = {ATTR_RESET, CHAR_SPACE};
         end
      end else if (cmd.move) begin
         // read one line below, write back the word fetched last cycle
         mem_ra = src_wide[AW-1:0];
         mem_we = (cnt_ff != '0);
         mem_wa = cnt_ff - AW'(1);
         mem_wd = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.sweep_start) begin
         cnt_in = '0;
      end else if (cmd.fill || (cmd.move && !status.move_last)) begin
         cnt_in = cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            attr_ff <= csr_wdata;
         end
         if (cmd.step) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.respond) begin
         rsp_ff.cursor_location <= loc_wide[10:0];
         rsp_ff.read_cell       <= (req_ff.opcode == OP_READ && req_in_range) ?
                                   rd_data_ff : 16'h0000;
      end
   end

   assign status.opcode    = req_ff.opcode;
   assign status.scroll    = scroll;
   assign status.move_last = (cnt_ff == AW'(CELLS - COLUMNS));
   assign status.fill_last = (cnt_ff == AW'(CELLS - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor left the screen");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_move_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.move |-> (32'(cnt_ff) <= 32'(CELLS - COLUMNS)))
      else $error("scroll move ran past the last line");

endmodule

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int CELL_TOTAL   = COLUMNS * ROWS;
   localparam int ADDRESS_SPAN = 2048;
   localparam int TAB_STOP     = 8;

   localparam logic [1:0] OP_NOP              = 2'd3;
   localparam logic [7:0] CHAR_LAST_PRINTABLE = 8'h7F;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_wdata;

   // shadow copy of the console
   logic [15:0] screen_shadow [CELL_TOTAL];
   int          shadow_col;
   int          shadow_row;
   logic [7:0]  shadow_attr;

   rsp_type pending_replies [$];
   int      error_count = 0;

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #500_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void blank_from(int first);
      for (int i = first; i < CELL_TOTAL; i++) begin
         screen_shadow[i] = {shadow_attr, CHAR_SPACE};
      end
   endfunction

   function automatic void reset_shadow();
      shadow_attr = ATTR_RESET;
      shadow_col  = 0;
      shadow_row  = 0;
      blank_from(0);
   endfunction

   function automatic void put_on_screen(logic [7:0] c);
      if (c == CHAR_BACKSPACE) begin
         if (shadow_col != 0) shadow_col--;
      end else if (c == CHAR_TAB) begin
         shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
      end else if (c == CHAR_NEWLINE) begin
         shadow_col = 0;
         shadow_row++;
      end else if (c >= CHAR_SPACE && c <= CHAR_LAST_PRINTABLE) begin
         screen_shadow[shadow_row * COLUMNS + shadow_col] = {shadow_attr, c};
         shadow_col++;
      end
      if (shadow_col >= COLUMNS) begin
         shadow_col = 0;
         shadow_row++;
      end
      // scroll up one line and blank the bottom line
      if (shadow_row >= ROWS) begin
         for (int i = 0; i < CELL_TOTAL - COLUMNS; i++) begin
            screen_shadow[i] = screen_shadow[i + COLUMNS];
         end
         blank_from(CELL_TOTAL - COLUMNS);
         shadow_row = ROWS - 1;
      end
   endfunction

   function automatic rsp_type apply_to_screen(req_type r);
      rsp_type reply;
      reply = '0;
      case (r.opcode)
         OP_PUT: put_on_screen(r.char_code);
         OP_CLEAR: blank_from(0);
         OP_READ: begin
            if (r.cell_address < CELL_TOTAL) reply.read_cell = screen_shadow[r.cell_address];
         end
         default: ;
      endcase
      reply.cursor_location = 11'(shadow_row * COLUMNS + shadow_col);
      return reply;
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected result, cursor_location %0d read_cell %h",
                     $time, rsp_data.cursor_location, rsp_data.read_cell);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_data.cursor_location !== want.cursor_location) begin
               $display("%0t: cursor_location expected %0d, actual %0d",
                        $time, want.cursor_location, rsp_data.cursor_location);
               error_count++;
            end
            if (rsp_data.read_cell !== want.read_cell) begin
               $display("%0t: read_cell expected %h, actual %h",
                        $time, want.read_cell, rsp_data.read_cell);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // Called at a falling edge; returns at the falling edge after the
   // transaction is taken, with start still high.
   task automatic send_item(req_type r);
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_replies.push_back(apply_to_screen(r));
      @(negedge clock);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // drain every result, then let the block go quiet
   task automatic settle();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_attr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(logic [1:0] op, logic [7:0] c, logic [10:0] a);
      req_type r;
      r.opcode       = op;
      r.char_code    = c;
      r.cell_address = a;
      return r;
   endfunction

   task automatic put_item(logic [7:0] c);
      send_item(make_req(OP_PUT, c, 11'($urandom)));
   endtask

   task automatic read_item(int address);
      send_item(make_req(OP_READ, 8'($urandom), 11'(address)));
   endtask

   function automatic logic [10:0] pick_address();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 11'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      else if (pick < 7) return 11'($urandom_range(0, CELL_TOTAL - 1));
      else if (pick < 8) return 11'($urandom_range(CELL_TOTAL, ADDRESS_SPAN - 1));
      else return 11'($urandom_range(0, ADDRESS_SPAN - 1));
   endfunction

   function automatic logic [7:0] pick_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 66) return 8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE));
      else if (pick < 72) return CHAR_NEWLINE;
      else if (pick < 79) return CHAR_TAB;
      else if (pick < 86) return CHAR_BACKSPACE;
      else if (pick < 93) return 8'($urandom_range(0, CHAR_SPACE - 1));
      else return 8'($urandom_range(CHAR_LAST_PRINTABLE + 1, 8'hFF));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      r    = make_req(OP_NOP, 8'($urandom), 11'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
         r.opcode    = OP_PUT;
         r.char_code = pick_char();
      end else if (pick < 80) begin
         r.opcode = OP_CLEAR;
      end else if (pick < 96) begin
         r.opcode       = OP_READ;
         r.cell_address = pick_address();
      end
      return r;
   endfunction

   // bursts of random length; steady mode sends back to back
   task automatic run_traffic(int count, bit steady);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < count) begin
            send_item(random_request());
            burst--;
            sent++;
         end
         if (!steady) begin
            pause(($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4));
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_power_up_screen();
      read_item(0);
      read_item(CELL_TOTAL - 1);
      read_item(CELL_TOTAL);
      read_item(ADDRESS_SPAN - 1);
      send_item(make_req(OP_NOP, 8'hFF, 11'h7FF));
      read_item(1);
   endtask

   task automatic test_control_bytes();
      put_item(CHAR_BACKSPACE);
      put_item(CHAR_SPACE);
      put_item(CHAR_LAST_PRINTABLE);
      put_item(8'h41);
      put_item(CHAR_BACKSPACE);
      put_item(CHAR_TAB);
      put_item(8'h00);
      put_item(8'h1F);
      put_item(8'h80);
      put_item(8'hFF);
      put_item(CHAR_NEWLINE);
      read_item(0);
      read_item(1);
      read_item(2);
   endtask

   task automatic test_clear_screen();
      write_attribute(8'hA5);
      put_item(8'h5A);
      send_item(make_req(OP_CLEAR, 8'h41, 11'h000));
      read_item(0);
      read_item(COLUMNS + 1);
   endtask

   // lines of random text: short lines, lines that wrap, runs of tabs
   task automatic test_scrolling_text();
      int kind;
      int length;
      write_attribute(8'h00);
      repeat (40) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            length = $urandom_range(0, 6);
            repeat (length) put_item(8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE)));
            put_item(CHAR_NEWLINE);
         end else if (kind == 7) begin
            length = $urandom_range(COLUMNS - 3, COLUMNS + 6);
            repeat (length) begin
               put_item(8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE)));
               if ($urandom_range(0, 15) == 0) pause($urandom_range(1, 3));
            end
         end else begin
            repeat ($urandom_range(9, 11)) put_item(CHAR_TAB);
         end
         if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 5));
         read_item(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
         read_item((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1));
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0] settings [5];
      settings[0] = 8'hFF;
      settings[1] = 8'($urandom);
      settings[2] = 8'($urandom);
      settings[3] = ATTR_RESET;
      settings[4] = 8'($urandom);
      for (int phase = 0; phase < 5; phase++) begin
         write_attribute(settings[phase]);
         run_traffic(150, phase == 2);
      end
   endtask

   initial begin
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      reset     = 1'b1;
      reset_shadow();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_up_screen();
      test_control_bytes();
      test_clear_screen();
      test_scrolling_text();
      test_random_traffic();
      settle();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
